### rtl/keypad_matrix_scan_debounce_macros.svh
// assertion macros for the keypad matrix scanner
`ifndef KEYPAD_MATRIX_SCAN_DEBOUNCE_MACROS_SVH
`define KEYPAD_MATRIX_SCAN_DEBOUNCE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define KMSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define KMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define KMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/kmsd_pkg.sv
// types, constants and key table for the keypad matrix scanner
package kmsd_pkg;

  localparam int unsigned RowW   = 4;
  localparam int unsigned ColW   = 3;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned TickW  = 8;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [ColW-1:0]  ALL_COLS         = 3'b111;
  localparam logic [1:0]       COL_END          = 2'd3;
  localparam logic [TickW-1:0] SETTLE_DEFAULT   = 8'd1;
  localparam logic [TickW-1:0] DEBOUNCE_DEFAULT = 8'd20;

  localparam logic [CodeW-1:0] KEY_STAR  = 4'd10;
  localparam logic [CodeW-1:0] KEY_POUND = 4'd11;

  // register index, taken from paddr[2]
  localparam logic REG_SETTLE   = 1'b0;
  localparam logic REG_DEBOUNCE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SCAN    = 3'd1,
    PH_DEB1    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DEB2    = 3'd4
  } phase_e;

  // key at row r, column c of the 4x3 pad
  function automatic logic [CodeW-1:0] key_lookup(input logic [1:0] row,
                                                  input logic [1:0] col);
    logic [CodeW-1:0] code;
    code = '0;
    case (row)
      2'd0: code = (col == 2'd0) ? 4'd1 : (col == 2'd1) ? 4'd2 : 4'd3;
      2'd1: code = (col == 2'd0) ? 4'd4 : (col == 2'd1) ? 4'd5 : 4'd6;
      2'd2: code = (col == 2'd0) ? 4'd7 : (col == 2'd1) ? 4'd8 : 4'd9;
      default: code = (col == 2'd0) ? KEY_STAR : (col == 2'd1) ? 4'd0 : KEY_POUND;
    endcase
    return code;
  endfunction

endpackage

### rtl/keypad_matrix_scan_debounce.sv
// keypad matrix scanner: 4x3 column scan with press and release debounce
// an accepted tick passes the input register, then the result register, before its result shows
// throughput: one tick transaction per cycle while the result side keeps taking
// the scan state advances once per tick in a single state machine step
// reset: asynchronous, active low; scan state to idle, registers to defaults; column drive not reset
`include "keypad_matrix_scan_debounce_macros.svh"

module keypad_matrix_scan_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmsd_pkg::RowW-1:0]     row_levels_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmsd_pkg::ColW-1:0]     col_drive_o,
  output logic                          press_done_o,
  output logic                          key_valid_o,
  output logic [kmsd_pkg::CodeW-1:0]    key_code_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmsd_pkg::PaddrW-1:0]   paddr,
  input  logic [kmsd_pkg::PdataW-1:0]   pwdata,
  output logic [kmsd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import kmsd_pkg::*;

  // configuration registers
  logic [TickW-1:0] settle_q, debounce_q;

  // input stage
  logic             s1_valid_q;
  logic [RowW-1:0]  s1_rows_q;
  logic             advance;

  // scan state
  phase_e           phase_q, phase_d;
  logic [1:0]       col_q, col_d;
  logic [TickW-1:0] wait_q, wait_d;
  logic [CodeW-1:0] key_q, key_d;
  logic             flag_q, flag_d;
  logic             confirm_q, confirm_d;

  // result register
  logic             out_valid_q;
  logic [ColW-1:0]  drive_q, drive_d;
  logic             done_q, done_d;
  logic             kvalid_q, kvalid_d;
  logic [CodeW-1:0] code_q, code_d;

  // step helpers
  logic             row_any;
  logic [1:0]       row_hi;
  logic [1:0]       col_nx;
  logic             col_hit;
  logic             scan_flag;

  // ---------------------------------------------------------------------------
  // register port: writes land in the access cycle, reads are combinational
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= SETTLE_DEFAULT;
      debounce_q <= DEBOUNCE_DEFAULT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SETTLE:   settle_q   <= pwdata[TickW-1:0];
        REG_DEBOUNCE: debounce_q <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SETTLE:   prdata = {{(PdataW-TickW){1'b0}}, settle_q};
      REG_DEBOUNCE: prdata = {{(PdataW-TickW){1'b0}}, debounce_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the input stage moves on whenever the result register is free
  // or being emptied in the same cycle
  // ---------------------------------------------------------------------------
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rows_q <= row_levels_i;
    end
  end

  // ---------------------------------------------------------------------------
  // row priority: the highest high row wins within a column
  // ---------------------------------------------------------------------------
  assign row_any = |s1_rows_q;

  always_comb begin
    row_hi = 2'd0;
    if (s1_rows_q[3])      row_hi = 2'd3;
    else if (s1_rows_q[2]) row_hi = 2'd2;
    else if (s1_rows_q[1]) row_hi = 2'd1;
    else                   row_hi = 2'd0;
  end

  assign col_nx    = col_q + 2'd1;
  assign col_hit   = (col_q < COL_END) && row_any;
  assign scan_flag = flag_q || col_hit;

  // ---------------------------------------------------------------------------
  // one tick of the scan state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d   = phase_q;
    col_d     = col_q;
    wait_d    = wait_q;
    key_d     = key_q;
    flag_d    = flag_q;
    confirm_d = confirm_q;
    drive_d   = ALL_COLS;
    done_d    = 1'b0;
    kvalid_d  = 1'b0;
    code_d    = '0;

    unique case (phase_q)
      PH_SCAN: begin
        if (wait_q != '0) begin
          // still settling on the current column
          wait_d  = wait_q - 8'd1;
          drive_d = (3'b001 << col_q) & ALL_COLS;
        end else begin
          // sample this column; a later column overrides an earlier hit
          if (col_hit) begin
            key_d  = key_lookup(row_hi, col_q);
            flag_d = 1'b1;
          end
          if (col_nx < COL_END) begin
            col_d   = col_nx;
            wait_d  = settle_q;
            drive_d = 3'b001 << col_nx;
          end else begin
            col_d = 2'd0;
            if (confirm_q) begin
              phase_d = PH_RELEASE;
            end else if (scan_flag) begin
              phase_d = PH_DEB1;
              wait_d  = debounce_q;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
      PH_DEB1: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 8'd1;
        end else if (row_any) begin
          // press still there: confirming scan
          phase_d   = PH_SCAN;
          col_d     = 2'd0;
          wait_d    = settle_q;
          flag_d    = 1'b0;
          key_d     = '0;
          confirm_d = 1'b1;
          drive_d   = 3'b001;
        end else begin
          // bounce only: skip the confirming scan, no key
          flag_d    = 1'b0;
          key_d     = '0;
          confirm_d = 1'b1;
          phase_d   = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (!row_any) begin
          phase_d = PH_DEB2;
          wait_d  = debounce_q;
        end
      end
      PH_DEB2: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 8'd1;
        end else begin
          done_d    = 1'b1;
          kvalid_d  = flag_q;
          code_d    = flag_q ? key_q : '0;
          phase_d   = PH_IDLE;
          confirm_d = 1'b0;
        end
      end
      default: begin
        // idle, and any unused code falls back to idle
        phase_d = PH_IDLE;
        if (row_any) begin
          phase_d   = PH_SCAN;
          col_d     = 2'd0;
          wait_d    = settle_q;
          flag_d    = 1'b0;
          key_d     = '0;
          confirm_d = 1'b0;
          drive_d   = 3'b001;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      col_q     <= 2'd0;
      wait_q    <= '0;
      key_q     <= '0;
      flag_q    <= 1'b0;
      confirm_q <= 1'b0;
    end else if (advance) begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      wait_q    <= wait_d;
      key_q     <= key_d;
      flag_q    <= flag_d;
      confirm_q <= confirm_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q  <= drive_d;
      done_q   <= done_d;
      kvalid_q <= kvalid_d;
      code_q   <= code_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign col_drive_o  = drive_q;
  assign press_done_o = done_q;
  assign key_valid_o  = kvalid_q;
  assign key_code_o   = code_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `KMSD_ASSERT_IMPL(a_done_all_cols, clk_i, rst_ni,
                    out_valid_o && press_done_o, col_drive_o == ALL_COLS,
                    "press report while a column is driven alone")
  `KMSD_ASSERT_IMPL(a_key_needs_done, clk_i, rst_ni,
                    out_valid_o && key_valid_o, press_done_o,
                    "key flagged without a completed press")
  `KMSD_ASSERT_IMPL(a_scan_col_range, clk_i, rst_ni,
                    phase_q == PH_SCAN, col_q != COL_END,
                    "scan column out of range")
  `KMSD_ASSERT_NEXT(a_state_holds, clk_i, rst_ni,
                    !advance, $stable(phase_q) && $stable(wait_q),
                    "scan state moved without a tick")

endmodule
